// ===== src/ddq_pkg.sv =====
// ddq_pkg: shared types and constants for the double-ended queue
// no dependencies; used by ddq_cell and double_ended_queue
`timescale 1ns / 1ps

package ddq_pkg;

    localparam int DATA_W = 64;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    typedef logic [DATA_W-1:0] data_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_PEEK       = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_FRONT,
        OP_PUSH_REAR,
        OP_POP_FRONT,
        OP_POP_REAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        data_t    value;
    } cell_ctrl_t;

    localparam data_t EMPTY_MARK = '1;

endpackage

// ===== src/double_ended_queue.sv =====
// double_ended_queue: top level, command decode, count, status and result register
// depends on ddq_pkg and ddq_cell
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 64-bit values held in a row of DEPTH cells.
// The front value always sits in the first cell: a push or pop at the front shifts
// the whole row by one place, a push or pop at the rear touches only the cell at the
// boundary of the occupied run. One item is taken per clock cycle; its result is
// presented in the next cycle and a new item is accepted in the same cycle that the
// previous result is taken, so back-to-back items run at one per cycle. The rear
// value is selected by an OR over all cells, whose depth sets the critical path.
// A push to a full queue or a pop from an empty one leaves the contents unchanged
// and is flagged in status; an empty queue reports -1 at both ends.

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ddq_pkg::CMD_W-1:0]       s_command,
    input  logic signed [ddq_pkg::DATA_W-1:0] s_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [ddq_pkg::DATA_W-1:0] m_front_value,
    output logic signed [ddq_pkg::DATA_W-1:0] m_rear_value,
    output logic [$clog2(DEPTH+1)-1:0]      m_entry_count,
    output logic                            m_is_empty,
    output logic [ddq_pkg::STAT_W-1:0]      m_status
);
    import ddq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    status_t          status_reg, status_next;
    logic             valid_reg, valid_next;
    cell_ctrl_t       ctrl;
    logic             accept;
    logic             is_full;
    logic             is_empty;

    logic  occ_w  [DEPTH];
    data_t data_w [DEPTH];
    data_t tap_w  [DEPTH];
    data_t rear_or;

    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign s_ready  = !valid_reg || m_ready;

    // command decode
    always_comb begin
        ctrl.op     = OP_HOLD;
        ctrl.value  = data_t'(s_value);
        count_next  = count_reg;
        status_next = status_reg;
        if (accept) begin
            status_next = ST_OK;
            case (cmd_t'(s_command))
                CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                    if (is_full) begin
                        status_next = ST_OVERFLOW;
                    end else begin
                        ctrl.op    = (cmd_t'(s_command) == CMD_PUSH_FRONT) ?
                                     OP_PUSH_FRONT : OP_PUSH_REAR;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP_FRONT, CMD_POP_REAR: begin
                    if (is_empty) begin
                        status_next = ST_UNDERFLOW;
                    end else begin
                        ctrl.op    = (cmd_t'(s_command) == CMD_POP_FRONT) ?
                                     OP_POP_FRONT : OP_POP_REAR;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                    ctrl.op = OP_HOLD;
                end
            endcase
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            status_reg <= ST_OK;
            valid_reg  <= 1'b0;
        end else begin
            count_reg  <= count_next;
            status_reg <= status_next;
            valid_reg  <= valid_next;
        end
    end

    // cell chain
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic  l_occ, r_occ;
        data_t l_data, r_data;

        if (i == 0) begin : g_head
            assign l_occ  = 1'b1;
            assign l_data = data_t'(s_value);
        end else begin : g_mid_l
            assign l_occ  = occ_w[i-1];
            assign l_data = data_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign r_occ  = 1'b0;
            assign r_data = data_w[i];
        end else begin : g_mid_r
            assign r_occ  = occ_w[i+1];
            assign r_data = data_w[i+1];
        end

        ddq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .left_occ   (l_occ),
            .left_data  (l_data),
            .right_occ  (r_occ),
            .right_data (r_data),
            .occ        (occ_w[i]),
            .data       (data_w[i]),
            .rear_tap   (tap_w[i])
        );
    end

    // only the last occupied cell drives a non-zero tap
    always_comb begin
        rear_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rear_or = rear_or | tap_w[k];
        end
    end

    assign m_valid       = valid_reg;
    assign m_entry_count = count_reg;
    assign m_is_empty    = is_empty;
    assign m_status      = status_reg;
    assign m_front_value = is_empty ? EMPTY_MARK : data_w[0];
    assign m_rear_value  = is_empty ? EMPTY_MARK : rear_or;

endmodule

// ===== src/ddq_cell.sv =====
// ddq_cell: one storage cell of the queue chain, holding a value and an occupied flag
// depends on ddq_pkg; neighbours in the chain feed it their contents every cycle
`timescale 1ns / 1ps

module ddq_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  ddq_pkg::cell_ctrl_t ctrl,
    input  logic                left_occ,
    input  ddq_pkg::data_t      left_data,
    input  logic                right_occ,
    input  ddq_pkg::data_t      right_data,
    output logic                occ,
    output ddq_pkg::data_t      data,
    output ddq_pkg::data_t      rear_tap
);
    import ddq_pkg::*;

    logic  occ_reg, occ_next;
    data_t data_reg, data_next;

    always_comb begin
        occ_next  = occ_reg;
        data_next = data_reg;
        case (ctrl.op)
            OP_PUSH_FRONT: begin
                occ_next  = left_occ;
                data_next = left_data;
            end
            OP_POP_FRONT: begin
                occ_next  = right_occ;
                data_next = right_data;
            end
            OP_PUSH_REAR: begin
                // first free cell behind the last occupied one
                if (!occ_reg && left_occ) begin
                    occ_next  = 1'b1;
                    data_next = ctrl.value;
                end
            end
            OP_POP_REAR: begin
                if (occ_reg && !right_occ) begin
                    occ_next = 1'b0;
                end
            end
            default: begin
                occ_next  = occ_reg;
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign occ      = occ_reg;
    assign data     = data_reg;
    assign rear_tap = (occ_reg && !right_occ) ? data_reg : '0;

endmodule

// ===== tb/tb_double_ended_queue.sv =====
// tb_double_ended_queue: self-checking testbench for the double-ended queue, a directed
// table followed by biased random traffic with random idling on both channels
// depends on ddq_pkg and double_ended_queue
`timescale 1ns / 1ps

module tb_double_ended_queue;

    import ddq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS = 525;
    localparam int SEGMENT_LEN  = 40;

    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    localparam data_t VAL_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam data_t VAL_MIN  = 64'h8000_0000_0000_0000;
    localparam data_t VAL_ZERO = '0;

    typedef struct packed {
        data_t             front;
        data_t             rear;
        logic [CNT_W-1:0]  count;
        logic              empty;
        logic [STAT_W-1:0] status;
    } deque_view_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        data_t            value;
        int               reps;
        bit               typed;
        deque_view_t      want;
    } script_row_t;

    typedef enum {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command = CMD_PEEK;
    logic signed [63:0]   s_value   = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic signed [63:0]   m_front_value;
    logic signed [63:0]   m_rear_value;
    logic [CNT_W-1:0]     m_entry_count;
    logic                 m_is_empty;
    logic [STAT_W-1:0]    m_status;

    double_ended_queue #(.DEPTH(DEPTH)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_front_value (m_front_value),
        .m_rear_value  (m_rear_value),
        .m_entry_count (m_entry_count),
        .m_is_empty    (m_is_empty),
        .m_status      (m_status)
    );

    data_t            ring [DEPTH];
    logic [3:0]       head_pos = '0;
    logic [CNT_W-1:0] held     = '0;

    deque_view_t expected_views [$];
    script_row_t script [$];

    int  mismatches    = 0;
    int  items_sent    = 0;
    int  views_checked = 0;
    int  overflows     = 0;
    int  underflows    = 0;
    int  full_hits     = 0;
    int  empty_hits    = 0;
    bit  steady_flow   = 1'b0;
    int  sink_hold     = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_double_ended_queue failed");
        $finish;
    end

    function automatic deque_view_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input data_t val);
        deque_view_t v;
        logic [3:0]  slot_at;
        v.status = ST_OK;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                if (held == DEPTH) begin
                    v.status = ST_OVERFLOW;
                    overflows++;
                end else if (cmd == CMD_PUSH_FRONT) begin
                    head_pos = head_pos - 4'd1;
                    ring[head_pos] = val;
                    held = held + 1'b1;
                end else begin
                    slot_at = head_pos + held[3:0];
                    ring[slot_at] = val;
                    held = held + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR: begin
                if (held == 0) begin
                    v.status = ST_UNDERFLOW;
                    underflows++;
                end else begin
                    if (cmd == CMD_POP_FRONT)
                        head_pos = head_pos + 4'd1;
                    held = held - 1'b1;
                end
            end
            default: ;
        endcase
        if (held == 0) begin
            v.front = EMPTY_MARK;
            v.rear  = EMPTY_MARK;
            v.empty = 1'b1;
            empty_hits++;
        end else begin
            slot_at = head_pos + held[3:0] - 4'd1;
            v.front = ring[head_pos];
            v.rear  = ring[slot_at];
            v.empty = 1'b0;
        end
        if (held == DEPTH)
            full_hits++;
        v.count = held;
        return v;
    endfunction

    function automatic int idle_length();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic data_t pick_value();
        int r;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: if (r < 12) return VAL_MAX;
            1: if (r < 12) return VAL_MIN;
            2: if (r < 12) return VAL_ZERO;
            default: if (r < 12) return EMPTY_MARK;
        endcase
        if (r < 35)
            return data_t'($signed(32'($urandom_range(0, 511)) - 256));
        return {$urandom, $urandom};
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input lean_t lean);
        int r;
        int push_pct;
        r = $urandom_range(0, 99);
        if (r < 4)
            return CMD_PEEK;
        if (r < 7)
            return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        push_pct = (lean == LEAN_FILL) ? 70 : (lean == LEAN_DRAIN) ? 22 : 48;
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
        return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
    endfunction

    function automatic void add_row(input logic [CMD_W-1:0] cmd, input data_t value,
                                    input int reps, input bit typed, input data_t front,
                                    input data_t rear, input int count, input logic empty,
                                    input logic [STAT_W-1:0] status);
        script_row_t row;
        row.cmd   = cmd;
        row.value = value;
        row.reps  = reps;
        row.typed = typed;
        row.want  = '{front, rear, CNT_W'(count), empty, status};
        script.push_back(row);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, name, $signed(want), $signed(got));
        end
    endfunction

    task automatic deliver(input logic [CMD_W-1:0] cmd, input data_t val, input bit typed,
                           input deque_view_t want);
        deque_view_t predicted;
        int gap;
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_value   <= val;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = apply_command(cmd, val);
        expected_views.push_back(typed ? want : predicted);
        items_sent++;
        gap = (steady_flow || $urandom_range(0, 99) < 55) ? 0 : idle_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            m_ready <= 1'b0;
            sink_hold--;
        end else if (!steady_flow && $urandom_range(0, 99) < 20) begin
            m_ready <= 1'b0;
            sink_hold = idle_length() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        deque_view_t got;
        deque_view_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_front_value, m_rear_value, m_entry_count, m_is_empty, m_status};
            if (expected_views.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result item, front %0d rear %0d count %0d",
                         $time, m_front_value, m_rear_value, m_entry_count);
            end else begin
                want = expected_views.pop_front();
                views_checked++;
                check_field("front_value", want.front, got.front);
                check_field("rear_value", want.rear, got.rear);
                check_field("entry_count", 64'(want.count), 64'(got.count));
                check_field("is_empty", 64'(want.empty), 64'(got.empty));
                check_field("status", 64'(want.status), 64'(got.status));
            end
        end
    end

    initial begin
        lean_t lean;
        add_row(CMD_PEEK,        VAL_ZERO, 1, 1, EMPTY_MARK, EMPTY_MARK, 0, 1, ST_OK);
        add_row(CMD_POP_FRONT,   VAL_ZERO, 1, 1, EMPTY_MARK, EMPTY_MARK, 0, 1, ST_UNDERFLOW);
        add_row(CMD_POP_REAR,    VAL_MAX,  1, 1, EMPTY_MARK, EMPTY_MARK, 0, 1, ST_UNDERFLOW);
        add_row(CMD_PUSH_REAR,   VAL_MAX,  1, 1, VAL_MAX, VAL_MAX, 1, 0, ST_OK);
        add_row(CMD_PUSH_FRONT,  VAL_MIN,  1, 1, VAL_MIN, VAL_MAX, 2, 0, ST_OK);
        add_row(CMD_SPARE_FIRST, VAL_ZERO, 1, 1, VAL_MIN, VAL_MAX, 2, 0, ST_OK);
        add_row(CMD_POP_REAR,    VAL_ZERO, 1, 1, VAL_MIN, VAL_MIN, 1, 0, ST_OK);
        add_row(CMD_POP_FRONT,   VAL_ZERO, 1, 1, EMPTY_MARK, EMPTY_MARK, 0, 1, ST_OK);
        add_row(CMD_PUSH_REAR,   VAL_ZERO, DEPTH - 2, 0, '0, '0, 0, 0, ST_OK);
        add_row(CMD_PUSH_FRONT,  VAL_ZERO, 1, 0, '0, '0, 0, 0, ST_OK);
        add_row(CMD_PUSH_REAR,   EMPTY_MARK, 1, 0, '0, '0, 0, 0, ST_OK);
        add_row(CMD_PUSH_FRONT,  VAL_MAX,  1, 1, VAL_ZERO, EMPTY_MARK, DEPTH, 0, ST_OVERFLOW);
        add_row(CMD_PUSH_REAR,   VAL_MIN,  1, 1, VAL_ZERO, EMPTY_MARK, DEPTH, 0, ST_OVERFLOW);
        add_row(CMD_SPARE_LAST,  VAL_MAX,  1, 1, VAL_ZERO, EMPTY_MARK, DEPTH, 0, ST_OK);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            for (int k = 0; k < script[i].reps; k++)
                deliver(script[i].cmd, (script[i].reps > 1) ? pick_value() : script[i].value,
                        script[i].typed, script[i].want);
        end
        wait_drained();

        lean = LEAN_DRAIN;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % SEGMENT_LEN == 0) begin
                lean = lean_t'($urandom_range(0, 2));
                steady_flow = ($urandom_range(0, 4) == 0);
            end
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            deliver(pick_command(lean), pick_value(), 1'b0, '0);
        end
        wait_drained();
        repeat (6) @(posedge aclk);

        $display("ran %0d items, %0d results checked: %0d overflows, %0d underflows",
                 items_sent, views_checked, overflows, underflows);
        $display("queue seen full after %0d items and empty after %0d items",
                 full_hits, empty_hits);
        if (mismatches == 0 && expected_views.size() == 0) begin
            $display("tb_double_ended_queue passed");
        end else begin
            $display("tb_double_ended_queue failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/ddq_pkg.sv
src/ddq_cell.sv
src/double_ended_queue.sv
tb/tb_double_ended_queue.sv
